[src/acrp_pkg.sv]
package acrp_pkg;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_ADDR = 4'd1;
   localparam logic [3:0] ST_OP   = 4'd2;
   localparam logic [3:0] ST_DEC  = 4'd3;
   localparam logic [3:0] ST_HEX  = 4'd4;
   localparam logic [3:0] ST_ID   = 4'd5;
   localparam logic [3:0] ST_BIT  = 4'd6;
   localparam logic [3:0] ST_HE   = 4'd7;
   localparam logic [3:0] ST_HL   = 4'd8;
   localparam logic [3:0] ST_HP   = 4'd9;
   localparam logic [3:0] ST_HEND = 4'd10;
   localparam logic [3:0] ST_HNUM = 4'd11;

   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_AND   = 2'd1;
   localparam logic [1:0] OP_OR    = 2'd2;
   localparam logic [1:0] OP_BIT   = 2'd3;

   localparam logic [2:0] KIND_READ = 3'd0;
   localparam logic [2:0] KIND_BIT  = 3'd4;
   localparam logic [2:0] KIND_HELP = 3'd5;

   localparam logic [15:0] HELP_SUMMARY = 16'hFFFF;
   localparam logic [7:0]  BIT_LIMIT    = 8'd16;

   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_EQUAL  = 8'h3D;
   localparam logic [7:0] CH_AMP    = 8'h26;
   localparam logic [7:0] CH_PIPE   = 8'h7C;
   localparam logic [7:0] CH_CARET  = 8'h5E;
   localparam logic [7:0] CH_AT     = 8'h40;
   localparam logic [7:0] CH_QUEST  = 8'h3F;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_DASH   = 8'h2D;
   localparam logic [7:0] CH_LOW_X  = 8'h78;
   localparam logic [7:0] CH_UP_X   = 8'h58;
   localparam logic [7:0] CH_LOW_H  = 8'h68;
   localparam logic [7:0] CH_LOW_E  = 8'h65;
   localparam logic [7:0] CH_LOW_L  = 8'h6C;
   localparam logic [7:0] CH_LOW_P  = 8'h70;

   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] address;
      logic [15:0] value;
      logic [3:0]  bit_index;
   } acrp_result_type;

   function automatic logic is_dec(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   // {valid, nibble}
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [7:0] t;
      t = 8'd0;
      if (is_dec(c)) begin
         t = c - 8'h30;
         return {1'b1, t[3:0]};
      end
      if ((c >= 8'h41) && (c <= 8'h46)) begin
         t = c - 8'h37;
         return {1'b1, t[3:0]};
      end
      if ((c >= 8'h61) && (c <= 8'h66)) begin
         t = c - 8'h57;
         return {1'b1, t[3:0]};
      end
      return 5'd0;
   endfunction

   function automatic logic [15:0] mul10_add16(input logic [15:0] a, input logic [3:0] d);
      return (a << 3) + (a << 1) + {12'd0, d};
   endfunction

   function automatic logic [7:0] mul10_add8(input logic [7:0] a, input logic [3:0] d);
      return (a << 3) + (a << 1) + {4'd0, d};
   endfunction

endpackage

[src/acrp_parser.sv]
module acrp_parser
   import acrp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            beat,
   input  logic [7:0]      rx_byte,
   input  logic [7:0]      node_id,
   output logic            res_valid,
   output acrp_result_type res
);

   logic [3:0]  state_ff, state_in;
   logic [15:0] addr_ff, addr_in;
   logic [15:0] value_ff, value_in;
   logic [7:0]  id_ff, id_in;
   logic [7:0]  bit_ff, bit_in;
   logic [1:0]  op_ff, op_in;

   logic        dec;
   logic [3:0]  digit;
   logic [4:0]  hex;
   logic [7:0]  help_want;
   logic [3:0]  help_next;

   assign dec   = is_dec(rx_byte);
   assign digit = rx_byte[3:0];
   assign hex   = hex_digit(rx_byte);

   always_comb begin
      case (state_ff)
         ST_HE:   begin help_want = CH_LOW_E; help_next = ST_HL;   end
         ST_HL:   begin help_want = CH_LOW_L; help_next = ST_HP;   end
         default: begin help_want = CH_LOW_P; help_next = ST_HEND; end
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      addr_in   = addr_ff;
      value_in  = value_ff;
      id_in     = id_ff;
      bit_in    = bit_ff;
      op_in     = op_ff;
      res_valid = 1'b0;
      res       = '0;
      if (beat) begin
         case (state_ff)
            ST_ADDR: begin
               if (rx_byte == CH_RBRACK) begin
                  state_in = ST_OP;
                  op_in    = OP_WRITE;
               end else if (dec) begin
                  addr_in = mul10_add16(addr_ff, digit);
               end else if (rx_byte == CH_AT) begin
                  id_in    = 8'd0;
                  state_in = ST_ID;
               end else if (rx_byte == CH_LBRACK) begin
                  addr_in = 16'd0;
               end else begin
                  state_in = ST_IDLE;
               end
            end
            ST_OP: begin
               if (rx_byte == CH_EQUAL) begin
                  state_in = ST_DEC;
                  value_in = 16'd0;
               end else if (rx_byte == CH_AMP) begin
                  op_in = OP_AND;
               end else if (rx_byte == CH_PIPE) begin
                  op_in = OP_OR;
               end else if (rx_byte == CH_CARET) begin
                  bit_in   = 8'd0;
                  state_in = ST_BIT;
               end else if (rx_byte == CH_LBRACK) begin
                  state_in = ST_ADDR;
                  addr_in  = 16'd0;
               end else begin
                  state_in = ST_IDLE;
               end
            end
            ST_DEC, ST_HEX: begin
               if (rx_byte == CH_QUEST) begin
                  res_valid   = 1'b1;
                  res.kind    = KIND_READ;
                  res.address = addr_ff;
                  state_in    = ST_IDLE;
               end else if (rx_byte == CH_DOT) begin
                  res_valid     = 1'b1;
                  res.kind      = {1'b0, op_ff} + 3'd1;
                  res.address   = addr_ff;
                  res.value     = value_ff;
                  res.bit_index = (op_ff == OP_BIT) ? bit_ff[3:0] : 4'd0;
                  state_in      = ST_IDLE;
               end else if (rx_byte == CH_LBRACK) begin
                  state_in = ST_ADDR;
                  addr_in  = 16'd0;
               end else if (state_ff == ST_DEC) begin
                  if (rx_byte == CH_LOW_X || rx_byte == CH_UP_X) begin
                     value_in = 16'd0;
                     state_in = ST_HEX;
                  end else if (dec) begin
                     value_in = mul10_add16(value_ff, digit);
                  end else begin
                     state_in = ST_IDLE;
                  end
               end else if (hex[4]) begin
                  value_in = {value_ff[11:0], hex[3:0]};
               end else begin
                  state_in = ST_IDLE;
               end
            end
            ST_ID: begin
               if (rx_byte == CH_RBRACK) begin
                  if (id_ff == node_id) begin
                     state_in = ST_OP;
                     op_in    = OP_WRITE;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end else if (dec) begin
                  id_in = mul10_add8(id_ff, digit);
               end else if (rx_byte == CH_LBRACK) begin
                  state_in = ST_ADDR;
                  addr_in  = 16'd0;
               end else begin
                  state_in = ST_IDLE;
               end
            end
            ST_BIT: begin
               if (rx_byte == CH_EQUAL) begin
                  if (bit_ff < BIT_LIMIT) begin
                     op_in    = OP_BIT;
                     value_in = 16'd0;
                     state_in = ST_DEC;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end else if (dec) begin
                  bit_in = mul10_add8(bit_ff, digit);
               end else if (rx_byte == CH_LBRACK) begin
                  state_in = ST_ADDR;
                  addr_in  = 16'd0;
               end else begin
                  state_in = ST_IDLE;
               end
            end
            ST_HE, ST_HL, ST_HP: begin
               if (rx_byte == help_want) begin
                  state_in = help_next;
               end else if (rx_byte == CH_LBRACK) begin
                  state_in = ST_ADDR;
                  addr_in  = 16'd0;
               end else begin
                  state_in = ST_IDLE;
               end
            end
            ST_HEND: begin
               if (rx_byte == CH_DOT) begin
                  res_valid = 1'b1;
                  res.kind  = KIND_HELP;
                  res.value = HELP_SUMMARY;
                  state_in  = ST_IDLE;
               end else if (rx_byte == CH_DASH) begin
                  value_in = 16'd0;
                  state_in = ST_HNUM;
               end else if (rx_byte == CH_LBRACK) begin
                  state_in = ST_ADDR;
                  addr_in  = 16'd0;
               end else begin
                  state_in = ST_IDLE;
               end
            end
            ST_HNUM: begin
               if (rx_byte == CH_DOT) begin
                  res_valid = 1'b1;
                  res.kind  = KIND_HELP;
                  res.value = value_ff;
                  state_in  = ST_IDLE;
               end else if (dec) begin
                  value_in = mul10_add16(value_ff, digit);
               end else if (rx_byte == CH_LBRACK) begin
                  state_in = ST_ADDR;
                  addr_in  = 16'd0;
               end else begin
                  state_in = ST_IDLE;
               end
            end
            default: begin
               if (rx_byte == CH_LBRACK) begin
                  state_in = ST_ADDR;
                  addr_in  = 16'd0;
               end else if (rx_byte == CH_LOW_H) begin
                  state_in = ST_HE;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         addr_ff  <= 16'd0;
         value_ff <= 16'd0;
         id_ff    <= 8'd0;
         bit_ff   <= 8'd0;
         op_ff    <= OP_WRITE;
      end else begin
         state_ff <= state_in;
         addr_ff  <= addr_in;
         value_ff <= value_in;
         id_ff    <= id_in;
         bit_ff   <= bit_in;
         op_ff    <= op_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_emit_to_idle: assert property (@(posedge clock) disable iff (reset)
      res_valid |=> state_ff == ST_IDLE)
      else $error("parser not idle after a result");

   a_hold_no_beat: assert property (@(posedge clock) disable iff (reset)
      !beat |=> $stable(state_ff) && $stable(addr_ff) && $stable(value_ff))
      else $error("parser state moved without a beat");

   a_bit_index_use: assert property (@(posedge clock) disable iff (reset)
      res_valid && res.kind != KIND_BIT |-> res.bit_index == 4'd0)
      else $error("bit index set on a non bit write result");

   a_help_addr: assert property (@(posedge clock) disable iff (reset)
      res_valid && res.kind == KIND_HELP |-> res.address == 16'd0)
      else $error("help result carries an address");
`endif

endmodule

[src/ascii_register_command_parser.sv]
// channel | direction | handshake          | payload
// req     | in        | req_valid/req_stall | req_rx_byte
// rsp     | out       | rsp_valid/rsp_stall | rsp_command_kind, rsp_reg_address,
//         |           |                     | rsp_reg_value, rsp_bit_index
// csr     | in        | csr_valid/csr_ready | csr_node_id
//
// One byte per cycle while req_stall is low; parsed in the cycle it is accepted.
// A result is registered into the output entry, or the skid entry if it is busy.
// Synchronous active high reset returns the parser to idle, node id to 0.
// Results go through a two entry output buffer; req_stall rises only when
// both entries are full.
module ascii_register_command_parser
   import acrp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_command_kind,
   output logic [15:0] rsp_reg_address,
   output logic [15:0] rsp_reg_value,
   output logic [3:0]  rsp_bit_index,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_node_id
);

   logic            beat;
   logic            res_valid;
   acrp_result_type res;
   logic [7:0]      node_id_ff;
   logic            out_valid_ff;
   acrp_result_type out_ff;
   logic            skid_valid_ff;
   acrp_result_type skid_ff;
   logic            out_take;

   assign req_stall = skid_valid_ff;
   assign beat      = req_valid & ~req_stall;
   assign csr_ready = 1'b1;
   assign out_take  = out_valid_ff & ~rsp_stall;

   acrp_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .beat      (beat),
      .rx_byte   (req_rx_byte),
      .node_id   (node_id_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         node_id_ff <= 8'd0;
      end else if (csr_valid && csr_ready) begin
         node_id_ff <= csr_node_id;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (out_take) begin
            out_ff        <= skid_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (res_valid) begin
         if (!out_valid_ff || out_take) begin
            out_ff       <= res;
            out_valid_ff <= 1'b1;
         end else begin
            skid_ff       <= res;
            skid_valid_ff <= 1'b1;
         end
      end else if (out_take) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_command_kind = out_ff.kind;
   assign rsp_reg_address  = out_ff.address;
   assign rsp_reg_value    = out_ff.value;
   assign rsp_bit_index    = out_ff.bit_index;

`ifndef NO_ASSERTIONS
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held with empty output");

   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      res_valid && out_valid_ff && rsp_stall |=> skid_valid_ff)
      else $error("result not parked while output stalled");

   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && out_take |=> out_valid_ff && !skid_valid_ff)
      else $error("skid entry not moved to output");
`endif

endmodule
